/* rtl/round_robin_thread_scheduler_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the round robin thread scheduler
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

/* rtl/rrts_pkg.sv */
// ---------------------------------------------------------------------------
// rrts_pkg
// Types, codes and helpers shared by the scheduler front, queue and back.
// ---------------------------------------------------------------------------
package rrts_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int IDLE_SLOT   = 3;
    localparam int SLOT_BITS   = 3;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int SCAN_W      = $clog2(NUM_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QUANTUM_W   = 16;
    localparam int TICK_W      = 64;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

    localparam bit IDLE_IN_RANGE = (IDLE_SLOT < NUM_SLOTS);

    typedef logic [SLOT_W-1:0] slot_idx_t;

    localparam slot_idx_t IDLE_IDX        = SLOT_W'(IDLE_SLOT % NUM_SLOTS);
    localparam slot_idx_t SCAN_IDLE_START = SLOT_W'((IDLE_SLOT + 1) % NUM_SLOTS);
    localparam slot_idx_t LAST_IDX        = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_TICK    = 3'd1,
        OP_REQUEST = 3'd2,
        OP_POINT   = 3'd3,
        OP_URET    = 3'd4,
        OP_WAKE    = 3'd5,
        OP_RESTART = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        RSN_YIELD  = 3'd0,
        RSN_IPC    = 3'd1,
        RSN_NOTIFY = 3'd2,
        RSN_EXIT   = 3'd3,
        RSN_FAULT  = 3'd4
    } reason_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FATAL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TH_RUNNABLE = 2'd0,
        TH_RUNNING  = 2'd1,
        TH_STOPPED  = 2'd2
    } thread_t;

    typedef enum logic [1:0] {
        TK_RUNNABLE = 2'd0,
        TK_RUNNING  = 2'd1,
        TK_BLOCKED  = 2'd2,
        TK_DEAD     = 2'd3
    } task_t;

    typedef enum logic [3:0] {
        CMD_START,
        CMD_TICK,
        CMD_REQUEST,
        CMD_POINT,
        CMD_URET,
        CMD_WAKE,
        CMD_RESTART,
        CMD_REJECT,
        CMD_FATAL
    } cmd_kind_t;

    typedef enum logic [1:0] {
        UR_YIELD,
        UR_BLOCK,
        UR_DIE
    } uret_t;

    typedef struct packed {
        cmd_kind_t kind;
        slot_idx_t slot;
        uret_t     uret;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_SCAN,
        BK_SWITCH,
        BK_DONE
    } back_state_t;

    function automatic logic is_idle(input slot_idx_t idx);
        return SLOT_BITS'(idx) == SLOT_BITS'(IDLE_SLOT);
    endfunction

    function automatic logic slot_runs(input thread_t th, input task_t tk, input logic idle);
        logic th_ok;
        logic tk_ok;
        th_ok = (th == TH_RUNNABLE) || (th == TH_RUNNING);
        tk_ok = idle || !((tk == TK_DEAD) || (tk == TK_BLOCKED));
        return th_ok && tk_ok;
    endfunction

endpackage

/* rtl/rrts_channels.sv */
// ---------------------------------------------------------------------------
// Scheduler channels
// Valid/ready interfaces for the event input and the result output.
// ---------------------------------------------------------------------------
interface rrts_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [2:0] slot;
    logic [2:0] reason;

    modport source (output valid, output opcode, output slot, output reason, input ready);
    modport sink   (input valid, input opcode, input slot, input reason, output ready);
endinterface

interface rrts_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        switched;
    logic [2:0]  running_slot;
    logic        running_valid;
    logic        pending_flag;
    logic        death_valid;
    logic [2:0]  death_slot;
    logic [63:0] tick_total;

    modport source (
        output valid, output status, output switched, output running_slot,
        output running_valid, output pending_flag, output death_valid,
        output death_slot, output tick_total, input ready
    );
    modport sink (
        input valid, input status, input switched, input running_slot,
        input running_valid, input pending_flag, input death_valid,
        input death_slot, input tick_total, output ready
    );
endinterface

/* rtl/round_robin_thread_scheduler_top.sv */
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Round robin thread scheduler with a per-slot tick quantum.
// ---------------------------------------------------------------------------
// One event in, one result out. The front classifies each event into a
// two-entry command queue; the back executes one command at a time. A plain
// event passes through pop, apply and result in the back, with a switch step
// added when it switches slots; a consumed reschedule adds a scan that visits
// one slot per cycle. The result stays in an output register until taken
// while the front keeps accepting into the queue. The quantum register takes
// effect on the next event.
module round_robin_thread_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    rrts_evt_if.sink    evt,
    rrts_res_if.source  res
);

`include "round_robin_thread_scheduler_top_macros.svh"

    logic                           push_valid;
    logic                           push_ready;
    rrts_pkg::cmd_t                 push_cmd;
    logic                           pop_valid;
    logic                           pop_ready;
    rrts_pkg::cmd_t                 pop_cmd;
    logic [rrts_pkg::QUANTUM_W-1:0] quantum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrts_pkg::QUANTUM_RESET;
        end
        else if (cfg_we)
        begin
            quantum_reg <= cfg_wdata;
        end
    end

    rrts_front u_front (
        .evt        (evt),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    rrts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    rrts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .quantum   (quantum_reg),
        .res       (res)
    );

    `RRTS_ASSERT_NOW(a_failed_is_clean, res.valid && (res.status != rrts_pkg::ST_OK),
        !res.switched && !res.death_valid)
    `RRTS_ASSERT_NOW(a_dead_slot_left, res.valid && res.death_valid,
        res.running_valid && (res.running_slot != res.death_slot))
    `RRTS_ASSERT_NEXT(a_running_holds, res.valid && res.ready && res.running_valid,
        !res.valid || res.running_valid)

endmodule

/* rtl/rrts_front.sv */
// ---------------------------------------------------------------------------
// rrts_front
// Accepts events and classifies them into queue commands, settling every
// check that does not depend on scheduler state.
// ---------------------------------------------------------------------------
module rrts_front (
    rrts_evt_if.sink       evt,
    output logic           push_valid,
    input  logic           push_ready,
    output rrts_pkg::cmd_t push_cmd
);

    logic slot_in_range;
    logic slot_is_idle;

    assign slot_in_range = ({1'b0, evt.slot} < 4'(rrts_pkg::NUM_SLOTS));
    assign slot_is_idle  = (evt.slot == rrts_pkg::SLOT_BITS'(rrts_pkg::IDLE_SLOT));

    assign push_valid = evt.valid;
    assign evt.ready  = push_ready;

    always_comb
    begin
        push_cmd.slot = evt.slot[rrts_pkg::SLOT_W-1:0];
        push_cmd.uret = rrts_pkg::UR_YIELD;
        push_cmd.kind = rrts_pkg::CMD_REJECT;
        case (evt.opcode)
            rrts_pkg::OP_START:
            begin
                push_cmd.kind = slot_in_range ? rrts_pkg::CMD_START : rrts_pkg::CMD_REJECT;
            end
            rrts_pkg::OP_TICK:    push_cmd.kind = rrts_pkg::CMD_TICK;
            rrts_pkg::OP_REQUEST: push_cmd.kind = rrts_pkg::CMD_REQUEST;
            rrts_pkg::OP_POINT:   push_cmd.kind = rrts_pkg::CMD_POINT;
            rrts_pkg::OP_URET:
            begin
                push_cmd.kind = rrts_pkg::CMD_URET;
                if (evt.reason == rrts_pkg::RSN_YIELD)
                begin
                    push_cmd.uret = rrts_pkg::UR_YIELD;
                end
                else if (evt.reason inside {rrts_pkg::RSN_IPC, rrts_pkg::RSN_NOTIFY})
                begin
                    push_cmd.uret = rrts_pkg::UR_BLOCK;
                end
                else if (evt.reason inside {rrts_pkg::RSN_EXIT, rrts_pkg::RSN_FAULT})
                begin
                    push_cmd.uret = rrts_pkg::UR_DIE;
                end
                else
                begin
                    push_cmd.kind = rrts_pkg::CMD_FATAL;
                end
            end
            rrts_pkg::OP_WAKE:
            begin
                push_cmd.kind = (slot_in_range && !slot_is_idle) ?
                                rrts_pkg::CMD_WAKE : rrts_pkg::CMD_FATAL;
            end
            rrts_pkg::OP_RESTART:
            begin
                push_cmd.kind = (slot_in_range && !slot_is_idle) ?
                                rrts_pkg::CMD_RESTART : rrts_pkg::CMD_REJECT;
            end
            default: push_cmd.kind = rrts_pkg::CMD_REJECT;
        endcase
    end

endmodule

/* rtl/rrts_queue.sv */
// ---------------------------------------------------------------------------
// rrts_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module rrts_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rrts_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rrts_pkg::cmd_t pop_cmd
);

    rrts_pkg::cmd_t              mem_reg [rrts_pkg::QUEUE_DEPTH];
    logic [rrts_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rrts_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [rrts_pkg::QCNT_W-1:0] count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != rrts_pkg::QCNT_W'(rrts_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* rtl/rrts_back.sv */
// ---------------------------------------------------------------------------
// rrts_back
// Executes queued commands on the slot state: applies the event, scans
// slots round robin one per cycle when a reschedule is consumed, switches
// in the pick and commits or drops the work copy into the result register.
// ---------------------------------------------------------------------------
module rrts_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  rrts_pkg::cmd_t                      pop_cmd,
    input  logic [rrts_pkg::QUANTUM_W-1:0]      quantum,
    rrts_res_if.source                          res
);

    rrts_pkg::back_state_t state_reg;
    rrts_pkg::back_state_t state_next;

    // committed state
    rrts_pkg::thread_t            st_th_reg [rrts_pkg::NUM_SLOTS];
    rrts_pkg::task_t              st_tk_reg [rrts_pkg::NUM_SLOTS];
    logic [rrts_pkg::QUANTUM_W-1:0] st_q_reg [rrts_pkg::NUM_SLOTS];
    rrts_pkg::slot_idx_t          cur_reg;
    logic                         present_reg;
    logic                         flag_reg;
    logic [rrts_pkg::TICK_W-1:0]  tick_reg;

    // work copy
    rrts_pkg::thread_t            ws_th_reg [rrts_pkg::NUM_SLOTS];
    rrts_pkg::task_t              ws_tk_reg [rrts_pkg::NUM_SLOTS];
    logic [rrts_pkg::QUANTUM_W-1:0] ws_q_reg [rrts_pkg::NUM_SLOTS];
    rrts_pkg::slot_idx_t          ws_cur_reg;
    logic                         ws_present_reg;
    logic                         ws_flag_reg;
    logic [rrts_pkg::TICK_W-1:0]  ws_tick_reg;

    rrts_pkg::cmd_t               cmd_reg;
    rrts_pkg::status_t            status_reg;
    logic                         sw_reg;
    logic                         died_reg;
    rrts_pkg::slot_idx_t          dslot_reg;
    rrts_pkg::slot_idx_t          scan_k_reg;
    logic [rrts_pkg::SCAN_W-1:0]  scan_cnt_reg;
    rrts_pkg::slot_idx_t          pick_reg;
    logic                         out_valid_reg;

    rrts_pkg::status_t            prep_status;
    logic                         prep_scan;
    logic                         prep_switch;
    rrts_pkg::slot_idx_t          scan_start;
    logic [rrts_pkg::QUANTUM_W-1:0] tick_q_dec;
    logic                         cand_ok;
    logic                         scan_last;
    logic                         fb_cur_ok;
    logic                         fb_idle_ok;
    logic                         same_slot;
    logic                         out_load;
    logic                         commit_ok;

    assign tick_q_dec = (st_q_reg[cur_reg] != '0) ? st_q_reg[cur_reg] - 1'b1 : '0;

    assign scan_start = !present_reg ? rrts_pkg::SCAN_IDLE_START :
                        (cur_reg == rrts_pkg::LAST_IDX) ? '0 : cur_reg + 1'b1;

    assign cand_ok = !rrts_pkg::is_idle(scan_k_reg) &&
                     (!ws_present_reg || (scan_k_reg != ws_cur_reg)) &&
                     rrts_pkg::slot_runs(ws_th_reg[scan_k_reg], ws_tk_reg[scan_k_reg], 1'b0);
    assign scan_last  = (scan_cnt_reg == rrts_pkg::SCAN_W'(rrts_pkg::NUM_SLOTS - 1));
    assign fb_cur_ok  = ws_present_reg && !rrts_pkg::is_idle(ws_cur_reg) &&
                        rrts_pkg::slot_runs(ws_th_reg[ws_cur_reg], ws_tk_reg[ws_cur_reg], 1'b0);
    assign fb_idle_ok = rrts_pkg::IDLE_IN_RANGE &&
                        rrts_pkg::slot_runs(ws_th_reg[rrts_pkg::IDLE_IDX],
                                            ws_tk_reg[rrts_pkg::IDLE_IDX], 1'b1);
    assign same_slot  = ws_present_reg && (ws_cur_reg == pick_reg);

    assign out_load  = (state_reg == rrts_pkg::BK_DONE) && (!out_valid_reg || res.ready);
    assign commit_ok = (status_reg == rrts_pkg::ST_OK);

    always_comb
    begin
        prep_status = rrts_pkg::ST_OK;
        prep_scan   = 1'b0;
        prep_switch = 1'b0;
        case (cmd_reg.kind)
            rrts_pkg::CMD_START:  prep_switch = 1'b1;
            rrts_pkg::CMD_POINT:  prep_scan   = flag_reg;
            rrts_pkg::CMD_URET:
            begin
                if (!present_reg || rrts_pkg::is_idle(cur_reg))
                begin
                    prep_status = rrts_pkg::ST_FATAL;
                end
                else
                begin
                    prep_scan = 1'b1;
                end
            end
            rrts_pkg::CMD_WAKE:
            begin
                if ((st_th_reg[cmd_reg.slot] == rrts_pkg::TH_STOPPED) ||
                    (st_tk_reg[cmd_reg.slot] == rrts_pkg::TK_DEAD))
                begin
                    prep_status = rrts_pkg::ST_FATAL;
                end
            end
            rrts_pkg::CMD_RESTART:
            begin
                if ((st_tk_reg[cmd_reg.slot] != rrts_pkg::TK_DEAD) ||
                    (st_th_reg[cmd_reg.slot] != rrts_pkg::TH_STOPPED))
                begin
                    prep_status = rrts_pkg::ST_REJECT;
                end
            end
            rrts_pkg::CMD_REJECT: prep_status = rrts_pkg::ST_REJECT;
            rrts_pkg::CMD_FATAL:  prep_status = rrts_pkg::ST_FATAL;
            default:              prep_status = rrts_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrts_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = rrts_pkg::BK_PREP;
                end
            end
            rrts_pkg::BK_PREP:
            begin
                if (prep_status != rrts_pkg::ST_OK)
                begin
                    state_next = rrts_pkg::BK_DONE;
                end
                else if (prep_scan)
                begin
                    state_next = rrts_pkg::BK_SCAN;
                end
                else if (prep_switch)
                begin
                    state_next = rrts_pkg::BK_SWITCH;
                end
                else
                begin
                    state_next = rrts_pkg::BK_DONE;
                end
            end
            rrts_pkg::BK_SCAN:
            begin
                if (cand_ok)
                begin
                    state_next = rrts_pkg::BK_SWITCH;
                end
                else if (scan_last)
                begin
                    state_next = (fb_cur_ok || fb_idle_ok) ? rrts_pkg::BK_SWITCH :
                                                             rrts_pkg::BK_DONE;
                end
            end
            rrts_pkg::BK_SWITCH: state_next = rrts_pkg::BK_DONE;
            rrts_pkg::BK_DONE:
            begin
                if (out_load)
                begin
                    state_next = rrts_pkg::BK_IDLE;
                end
            end
            default: state_next = rrts_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == rrts_pkg::BK_IDLE);
        res.valid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrts_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            present_reg   <= 1'b0;
            flag_reg      <= 1'b0;
            tick_reg      <= '0;
            for (int k = 0; k < rrts_pkg::NUM_SLOTS; k++)
            begin
                st_th_reg[k] <= rrts_pkg::TH_RUNNABLE;
                st_tk_reg[k] <= rrts_pkg::is_idle(rrts_pkg::SLOT_W'(k)) ?
                                rrts_pkg::TK_DEAD : rrts_pkg::TK_RUNNABLE;
                st_q_reg[k]  <= rrts_pkg::QUANTUM_RESET;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load && commit_ok)
            begin
                for (int k = 0; k < rrts_pkg::NUM_SLOTS; k++)
                begin
                    st_th_reg[k] <= ws_th_reg[k];
                    st_tk_reg[k] <= ws_tk_reg[k];
                    st_q_reg[k]  <= ws_q_reg[k];
                end
                cur_reg     <= ws_cur_reg;
                present_reg <= ws_present_reg;
                flag_reg    <= ws_flag_reg;
                tick_reg    <= ws_tick_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rrts_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_reg <= pop_cmd;
                end
            end
            rrts_pkg::BK_PREP:
            begin
                for (int k = 0; k < rrts_pkg::NUM_SLOTS; k++)
                begin
                    ws_th_reg[k] <= st_th_reg[k];
                    ws_tk_reg[k] <= st_tk_reg[k];
                    ws_q_reg[k]  <= st_q_reg[k];
                end
                ws_cur_reg     <= cur_reg;
                ws_present_reg <= present_reg;
                ws_flag_reg    <= flag_reg;
                ws_tick_reg    <= tick_reg;
                status_reg     <= prep_status;
                sw_reg         <= 1'b0;
                died_reg       <= 1'b0;
                dslot_reg      <= '0;
                scan_k_reg     <= scan_start;
                scan_cnt_reg   <= '0;
                pick_reg       <= cmd_reg.slot;
                if (prep_status == rrts_pkg::ST_OK)
                begin
                    case (cmd_reg.kind)
                        rrts_pkg::CMD_TICK:
                        begin
                            ws_tick_reg <= tick_reg + 1'b1;
                            if (present_reg)
                            begin
                                if (tick_q_dec == '0)
                                begin
                                    ws_q_reg[cur_reg] <= quantum;
                                    ws_flag_reg       <= 1'b1;
                                end
                                else
                                begin
                                    ws_q_reg[cur_reg] <= tick_q_dec;
                                end
                            end
                        end
                        rrts_pkg::CMD_REQUEST: ws_flag_reg <= 1'b1;
                        rrts_pkg::CMD_POINT:   ws_flag_reg <= 1'b0;
                        rrts_pkg::CMD_URET:
                        begin
                            ws_flag_reg <= 1'b0;
                            case (cmd_reg.uret)
                                rrts_pkg::UR_YIELD:
                                begin
                                    ws_tk_reg[cur_reg] <= rrts_pkg::TK_RUNNABLE;
                                    ws_th_reg[cur_reg] <= rrts_pkg::TH_RUNNABLE;
                                end
                                rrts_pkg::UR_BLOCK:
                                begin
                                    ws_tk_reg[cur_reg] <= rrts_pkg::TK_BLOCKED;
                                    ws_th_reg[cur_reg] <= rrts_pkg::TH_RUNNABLE;
                                end
                                default:
                                begin
                                    ws_tk_reg[cur_reg] <= rrts_pkg::TK_DEAD;
                                    ws_th_reg[cur_reg] <= rrts_pkg::TH_STOPPED;
                                    died_reg           <= 1'b1;
                                    dslot_reg          <= cur_reg;
                                end
                            endcase
                        end
                        rrts_pkg::CMD_WAKE:
                        begin
                            ws_tk_reg[cmd_reg.slot] <= rrts_pkg::TK_RUNNABLE;
                            ws_th_reg[cmd_reg.slot] <= rrts_pkg::TH_RUNNABLE;
                        end
                        rrts_pkg::CMD_RESTART:
                        begin
                            ws_tk_reg[cmd_reg.slot] <= rrts_pkg::TK_RUNNABLE;
                            ws_th_reg[cmd_reg.slot] <= rrts_pkg::TH_RUNNABLE;
                            ws_flag_reg             <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            rrts_pkg::BK_SCAN:
            begin
                if (cand_ok)
                begin
                    pick_reg <= scan_k_reg;
                end
                else if (scan_last)
                begin
                    if (fb_cur_ok)
                    begin
                        pick_reg <= ws_cur_reg;
                    end
                    else if (fb_idle_ok)
                    begin
                        pick_reg <= rrts_pkg::IDLE_IDX;
                    end
                    else
                    begin
                        status_reg <= rrts_pkg::ST_FATAL;
                    end
                end
                else
                begin
                    scan_k_reg   <= (scan_k_reg == rrts_pkg::LAST_IDX) ? '0 : scan_k_reg + 1'b1;
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
            rrts_pkg::BK_SWITCH:
            begin
                if (!same_slot)
                begin
                    if (ws_present_reg && (ws_th_reg[ws_cur_reg] == rrts_pkg::TH_RUNNING))
                    begin
                        ws_th_reg[ws_cur_reg] <= rrts_pkg::TH_RUNNABLE;
                    end
                    ws_th_reg[pick_reg] <= rrts_pkg::TH_RUNNING;
                    ws_cur_reg          <= pick_reg;
                    ws_present_reg      <= 1'b1;
                    sw_reg              <= 1'b1;
                    if (ws_q_reg[pick_reg] == '0)
                    begin
                        ws_q_reg[pick_reg] <= quantum;
                    end
                    if (!rrts_pkg::is_idle(pick_reg) &&
                        (ws_tk_reg[pick_reg] == rrts_pkg::TK_RUNNABLE))
                    begin
                        ws_tk_reg[pick_reg] <= rrts_pkg::TK_RUNNING;
                    end
                end
                else if (cmd_reg.kind == rrts_pkg::CMD_URET)
                begin
                    ws_th_reg[pick_reg] <= rrts_pkg::TH_RUNNING;
                    ws_tk_reg[pick_reg] <= rrts_pkg::TK_RUNNING;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res.status        <= status_reg;
            res.switched      <= commit_ok && sw_reg;
            res.death_valid   <= commit_ok && died_reg;
            res.death_slot    <= commit_ok ? rrts_pkg::SLOT_BITS'(dslot_reg) : '0;
            if (commit_ok)
            begin
                res.running_slot  <= ws_present_reg ? rrts_pkg::SLOT_BITS'(ws_cur_reg) : '0;
                res.running_valid <= ws_present_reg;
                res.pending_flag  <= ws_flag_reg;
                res.tick_total    <= ws_tick_reg;
            end
            else
            begin
                res.running_slot  <= present_reg ? rrts_pkg::SLOT_BITS'(cur_reg) : '0;
                res.running_valid <= present_reg;
                res.pending_flag  <= flag_reg;
                res.tick_total    <= tick_reg;
            end
        end
    end

endmodule
